// File: src/tufr_pkg.sv
// tufr_pkg: types, constants and state encodings for the temporal reachability block
// no dependencies
`default_nettype none
package tufr_pkg;
    localparam int MAX_PEOPLE_DEF = 1024;
    localparam int MAX_BATCH_DEF  = 2048;
    localparam int PERSON_W = 10;
    localparam int COUNT_W  = 11;
    localparam int TIME_W   = 32;

    localparam logic       CMD_MEET  = 1'b0;
    localparam logic       CMD_QUERY = 1'b1;
    localparam logic [0:0] REG_PEOPLE_COUNT = 1'b0;
    localparam logic [0:0] REG_FIRST_PERSON = 1'b1;

    typedef struct packed {
        logic                command;
        logic [PERSON_W-1:0] person_a;
        logic [PERSON_W-1:0] person_b;
        logic [TIME_W-1:0]   meeting_time;
    } in_item_t;

    typedef struct packed {
        logic [PERSON_W-1:0] queried_person;
        logic                knows_secret;
        logic                order_error;
    } out_item_t;

    typedef enum logic [4:0] {
        ST_INIT,
        ST_IDLE,
        ST_DECIDE,
        ST_CL_FETCH,
        ST_CL_WAITM,
        ST_CL_START,
        ST_CL_WALK,
        ST_CL_WRITE,
        ST_Q_START,
        ST_Q_WALK,
        ST_Q_DONE,
        ST_M_START_A,
        ST_M_WALK_A,
        ST_M_START_B,
        ST_M_WALK_B,
        ST_M_LINK,
        ST_M_REC_A,
        ST_M_REC_B
    } state_t;
endpackage
`default_nettype wire

// File: src/temporal_union_find_reachability.sv
// temporal_union_find_reachability: top level, union-find over a parent memory
// depends on tufr_pkg
//
// channel   direction  handshake             payload
// s_        in         s_valid / s_ready     tufr_pkg::in_item_t
// m_        out        m_valid / m_ready     tufr_pkg::out_item_t
// cfg_      in         cfg_valid / cfg_ready cfg_index, cfg_data
//
// one transaction at a time; a root walk passes a start state and a walk state per parent link
// a meeting walks both roots and links them, a query walks one root,
// plus the batch close, which walks every member (every person in use if the list overflowed)
// after reset and after each config write the parent memory is swept, one entry a cycle,
// over all MAX_PEOPLE entries, during which no input transaction is taken
// the result sits in an output register; s_ready stays low until it is taken
// a pending config write holds s_ready low
`default_nettype none
module temporal_union_find_reachability #(
    parameter int MAX_PEOPLE = tufr_pkg::MAX_PEOPLE_DEF,
    parameter int MAX_BATCH_MEMBERS = tufr_pkg::MAX_BATCH_DEF
) (
    input  wire                    aclk,
    input  wire                    aresetn,
    input  wire                    s_valid,
    output logic                   s_ready,
    input  tufr_pkg::in_item_t     s_data,
    output logic                   m_valid,
    input  wire                    m_ready,
    output tufr_pkg::out_item_t    m_data,
    input  wire                    cfg_valid,
    output logic                   cfg_ready,
    input  wire  [0:0]             cfg_index,
    input  wire  [15:0]            cfg_data
);
    import tufr_pkg::*;

    localparam int PW = $clog2(MAX_PEOPLE);
    localparam int BW = $clog2(MAX_BATCH_MEMBERS);
    localparam int LW = BW + 1;
    localparam int NW = PW + 1;

    // memories
    logic [PW-1:0] parent_mem [MAX_PEOPLE];
    logic [PW-1:0] batch_mem  [MAX_BATCH_MEMBERS];

    logic          p_we;
    logic [PW-1:0] p_waddr, p_wdata, p_raddr, p_rdata;
    logic          b_we;
    logic [BW-1:0] b_waddr, b_raddr;
    logic [PW-1:0] b_wdata, b_rdata;

    always_ff @(posedge aclk) begin
        if (p_we) begin
            parent_mem[p_waddr] <= p_wdata;
        end
        p_rdata <= parent_mem[p_raddr];
    end

    always_ff @(posedge aclk) begin
        if (b_we) begin
            batch_mem[b_waddr] <= b_wdata;
        end
        b_rdata <= batch_mem[b_raddr];
    end

    // registers
    state_t        state_reg, state_next;
    logic [COUNT_W-1:0]  people_reg, people_next;
    logic [PERSON_W-1:0] first_reg, first_next;
    logic [NW-1:0] sweep_reg, sweep_next;
    logic [LW-1:0] blen_reg, blen_next;
    logic [LW-1:0] cidx_reg, cidx_next;
    logic [TIME_W-1:0] btime_reg, btime_next;
    logic          bopen_reg, bopen_next;
    logic          err_reg, err_next;
    logic          ovf_reg, ovf_next;
    in_item_t      item_reg, item_next;
    logic [PW-1:0] cur_reg, cur_next;
    logic [PW-1:0] node_reg, node_next;
    logic [PW-1:0] ra_reg, ra_next;
    logic          mval_reg, mval_next;
    out_item_t     mdata_reg, mdata_next;

    // people count clamped to [2, MAX_PEOPLE]
    logic [NW-1:0] n_use;
    always_comb begin
        if (people_reg < COUNT_W'(2)) begin
            n_use = NW'(2);
        end else if ({{(32-COUNT_W){1'b0}}, people_reg} > 32'(MAX_PEOPLE)) begin
            n_use = NW'(MAX_PEOPLE);
        end else begin
            n_use = NW'(people_reg);
        end
    end

    logic a_in, b_in, is_root;
    assign a_in = {{(32-PERSON_W){1'b0}}, item_reg.person_a} < 32'(n_use);
    assign b_in = {{(32-PERSON_W){1'b0}}, item_reg.person_b} < 32'(n_use);
    assign is_root = (p_rdata == cur_reg);

    assign s_ready   = (state_reg == ST_IDLE) && !mval_reg && !cfg_valid;
    assign cfg_ready = (state_reg == ST_IDLE) && !mval_reg;
    assign m_valid   = mval_reg;
    assign m_data    = mdata_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_INIT: begin
                if (sweep_reg == NW'(MAX_PEOPLE - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (cfg_valid && cfg_ready) begin
                    state_next = ST_INIT;
                end else if (s_valid && s_ready) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (item_reg.command == CMD_QUERY) begin
                    state_next = bopen_reg ? ST_CL_FETCH : ST_Q_START;
                end else if (!a_in || !b_in || item_reg.meeting_time < btime_reg) begin
                    state_next = ST_IDLE;
                end else if (bopen_reg && item_reg.meeting_time != btime_reg) begin
                    state_next = ST_CL_FETCH;
                end else begin
                    state_next = ST_M_START_A;
                end
            end
            ST_CL_FETCH: begin
                if ((ovf_reg && cidx_reg >= LW'(n_use)) || (!ovf_reg && cidx_reg >= blen_reg)) begin
                    state_next = (item_reg.command == CMD_QUERY) ? ST_Q_START : ST_M_START_A;
                end else begin
                    state_next = ovf_reg ? ST_CL_START : ST_CL_WAITM;
                end
            end
            ST_CL_WAITM: state_next = ST_CL_START;
            ST_CL_START: state_next = ST_CL_WALK;
            ST_CL_WALK: begin
                if (is_root) begin
                    state_next = ST_CL_WRITE;
                end else begin
                    state_next = ST_CL_START;
                end
            end
            ST_CL_WRITE: state_next = ST_CL_FETCH;
            ST_Q_START: state_next = a_in ? ST_Q_WALK : ST_Q_DONE;
            ST_Q_WALK: state_next = is_root ? ST_Q_DONE : ST_Q_START;
            ST_Q_DONE: state_next = ST_IDLE;
            ST_M_START_A: state_next = ST_M_WALK_A;
            ST_M_WALK_A: state_next = is_root ? ST_M_START_B : ST_M_START_A;
            ST_M_START_B: state_next = ST_M_WALK_B;
            ST_M_WALK_B: state_next = is_root ? ST_M_LINK : ST_M_START_B;
            ST_M_LINK: begin
                state_next = (blen_reg + LW'(2) <= LW'(MAX_BATCH_MEMBERS)) ? ST_M_REC_A : ST_IDLE;
            end
            ST_M_REC_A: state_next = ST_M_REC_B;
            ST_M_REC_B: state_next = ST_IDLE;
            default: state_next = ST_INIT;
        endcase
    end

    // datapath and memory control
    always_comb begin
        people_next = people_reg;
        first_next  = first_reg;
        sweep_next  = sweep_reg;
        blen_next   = blen_reg;
        cidx_next   = cidx_reg;
        btime_next  = btime_reg;
        bopen_next  = bopen_reg;
        err_next    = err_reg;
        ovf_next    = ovf_reg;
        item_next   = item_reg;
        cur_next    = cur_reg;
        node_next   = node_reg;
        ra_next     = ra_reg;
        mval_next   = mval_reg;
        mdata_next  = mdata_reg;
        p_we = 1'b0;
        p_waddr = cur_reg;
        p_wdata = cur_reg;
        p_raddr = cur_reg;
        b_we = 1'b0;
        b_waddr = blen_reg[BW-1:0];
        b_wdata = item_reg.person_a[PW-1:0];
        b_raddr = cidx_reg[BW-1:0];
        if (mval_reg && m_ready) begin
            mval_next = 1'b0;
        end
        case (state_reg)
            ST_INIT: begin
                p_we = 1'b1;
                p_waddr = sweep_reg[PW-1:0];
                if ({{(32-PERSON_W){1'b0}}, first_reg} < 32'(n_use)
                        && sweep_reg == NW'(first_reg)) begin
                    p_wdata = '0;
                end else begin
                    p_wdata = sweep_reg[PW-1:0];
                end
                sweep_next = sweep_reg + NW'(1);
                blen_next  = '0;
                btime_next = '0;
                bopen_next = 1'b0;
                err_next   = 1'b0;
                ovf_next   = 1'b0;
            end
            ST_IDLE: begin
                sweep_next = '0;
                cidx_next  = '0;
                if (cfg_valid && cfg_ready) begin
                    if (cfg_index == REG_PEOPLE_COUNT) begin
                        people_next = cfg_data[COUNT_W-1:0];
                    end else begin
                        first_next = cfg_data[PERSON_W-1:0];
                    end
                end else if (s_valid && s_ready) begin
                    item_next = s_data;
                end
            end
            ST_DECIDE: begin
                cidx_next = '0;
                if (item_reg.command == CMD_MEET && a_in && b_in
                        && item_reg.meeting_time < btime_reg) begin
                    err_next = 1'b1;
                end
            end
            ST_CL_FETCH: begin
                b_raddr = cidx_reg[BW-1:0];
                if ((ovf_reg && cidx_reg >= LW'(n_use)) || (!ovf_reg && cidx_reg >= blen_reg)) begin
                    blen_next  = '0;
                    bopen_next = 1'b0;
                    ovf_next   = 1'b0;
                end else if (ovf_reg) begin
                    node_next = cidx_reg[PW-1:0];
                    cur_next  = cidx_reg[PW-1:0];
                end
            end
            ST_CL_WAITM: begin
                node_next = b_rdata;
                cur_next  = b_rdata;
            end
            ST_CL_START: p_raddr = cur_reg;
            ST_CL_WALK: begin
                if (!is_root) begin
                    cur_next = p_rdata;
                end
            end
            ST_CL_WRITE: begin
                if (cur_reg != '0) begin
                    p_we = 1'b1;
                    p_waddr = node_reg;
                    p_wdata = node_reg;
                end
                cidx_next = cidx_reg + LW'(1);
            end
            ST_Q_START: p_raddr = cur_reg;
            ST_Q_WALK: begin
                if (!is_root) begin
                    cur_next = p_rdata;
                end
            end
            ST_Q_DONE: begin
                mval_next = 1'b1;
                mdata_next.queried_person = item_reg.person_a;
                mdata_next.knows_secret = a_in && (cur_reg == '0);
                mdata_next.order_error = err_reg;
            end
            ST_M_START_A: begin
                if (!bopen_reg) begin
                    bopen_next = 1'b1;
                    btime_next = item_reg.meeting_time;
                end
                p_raddr = cur_reg;
            end
            ST_M_WALK_A: begin
                if (is_root) begin
                    ra_next  = cur_reg;
                    cur_next = item_reg.person_b[PW-1:0];
                end else begin
                    cur_next = p_rdata;
                end
            end
            ST_M_START_B: p_raddr = cur_reg;
            ST_M_WALK_B: begin
                if (!is_root) begin
                    cur_next = p_rdata;
                end
            end
            ST_M_LINK: begin
                p_we = 1'b1;
                if (ra_reg > cur_reg) begin
                    p_waddr = ra_reg;
                    p_wdata = cur_reg;
                end else begin
                    p_waddr = cur_reg;
                    p_wdata = ra_reg;
                end
                if (!(blen_reg + LW'(2) <= LW'(MAX_BATCH_MEMBERS))) begin
                    ovf_next = 1'b1;
                end
            end
            ST_M_REC_A: begin
                b_we = 1'b1;
                b_waddr = blen_reg[BW-1:0];
                b_wdata = item_reg.person_a[PW-1:0];
                blen_next = blen_reg + LW'(1);
            end
            ST_M_REC_B: begin
                b_we = 1'b1;
                b_waddr = blen_reg[BW-1:0];
                b_wdata = item_reg.person_b[PW-1:0];
                blen_next = blen_reg + LW'(1);
            end
            default: begin
            end
        endcase
        // walk start point once the close is done or skipped
        if (state_next == ST_Q_START && state_reg != ST_Q_WALK) begin
            cur_next = item_reg.person_a[PW-1:0];
        end
        if (state_next == ST_M_START_A && state_reg != ST_M_WALK_A) begin
            cur_next = item_reg.person_a[PW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_INIT;
            people_reg <= COUNT_W'(MAX_PEOPLE_DEF);
            first_reg  <= PERSON_W'(1);
            sweep_reg  <= '0;
            blen_reg   <= '0;
            cidx_reg   <= '0;
            btime_reg  <= '0;
            bopen_reg  <= 1'b0;
            err_reg    <= 1'b0;
            ovf_reg    <= 1'b0;
            mval_reg   <= 1'b0;
        end else begin
            state_reg  <= state_next;
            people_reg <= people_next;
            first_reg  <= first_next;
            sweep_reg  <= sweep_next;
            blen_reg   <= blen_next;
            cidx_reg   <= cidx_next;
            btime_reg  <= btime_next;
            bopen_reg  <= bopen_next;
            err_reg    <= err_next;
            ovf_reg    <= ovf_next;
            mval_reg   <= mval_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg  <= item_next;
        cur_reg   <= cur_next;
        node_reg  <= node_next;
        ra_reg    <= ra_next;
        mdata_reg <= mdata_next;
    end
endmodule
`default_nettype wire

// File: src/tufr_checker.sv
// tufr_assertions: port-level assertions for the reachability block, bound to the top level
// depends on tufr_pkg
`default_nettype none
module tufr_assertions (
    input wire                  aclk,
    input wire                  aresetn,
    input wire                  s_valid,
    input wire                  s_ready,
    input tufr_pkg::in_item_t   s_data,
    input wire                  m_valid,
    input wire                  m_ready,
    input tufr_pkg::out_item_t  m_data,
    input wire                  cfg_valid,
    input wire                  cfg_ready
);
    import tufr_pkg::*;

    // result held while stalled
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // no new transaction while a result waits
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("input taken while result pending");

    // a meeting never produces a result
    a_meet: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.command == CMD_MEET |=> !m_valid)
        else $error("result after meeting");

    // nothing accepted in the cycle after reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !s_ready && !m_valid)
        else $error("ready during init sweep");
endmodule

bind temporal_union_find_reachability tufr_assertions u_tufr_assertions (
    .aclk(aclk), .aresetn(aresetn),
    .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
    .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready)
);
`default_nettype wire

// File: tb/tufr_checker.sv
// tufr_checker: watches the input, config and result channels of the temporal
// reachability block, predicts each query answer and compares it with the output
// depends on tufr_pkg
`timescale 1ns / 100ps
module tufr_checker (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_valid,
    input  wire                 s_ready,
    input  tufr_pkg::in_item_t  s_data,
    input  wire                 m_valid,
    input  wire                 m_ready,
    input  tufr_pkg::out_item_t m_data,
    input  wire                 cfg_valid,
    input  wire                 cfg_ready,
    input  wire  [0:0]          cfg_index,
    input  wire  [15:0]         cfg_data,
    output int                  fail_count,
    output int                  answers_due
);
    import tufr_pkg::*;

    localparam int PEOPLE_MAX = MAX_PEOPLE_DEF;
    localparam int MEMBERS_MAX = MAX_BATCH_DEF;

    logic [PERSON_W-1:0] parent [PEOPLE_MAX];
    logic [PERSON_W-1:0] members [$];
    out_item_t           answers [$];
    int unsigned         people_reg;
    int unsigned         first_reg;
    logic [TIME_W-1:0]   cur_time;
    bit                  open_batch;
    bit                  order_err;
    bit                  overflowed;

    function automatic int unsigned in_use();
        if (people_reg < 2) return 2;
        if (people_reg > PEOPLE_MAX) return PEOPLE_MAX;
        return people_reg;
    endfunction

    function automatic int unsigned find_root(int unsigned x);
        for (int k = 0; k < PEOPLE_MAX; k++) begin
            if (parent[x] == x) break;
            x = parent[x];
        end
        return x;
    endfunction

    function automatic void restart_table();
        for (int k = 0; k < PEOPLE_MAX; k++) parent[k] = PERSON_W'(k);
        if (first_reg < in_use()) parent[first_reg] = 0;
        members.delete();
        cur_time = 0;
        open_batch = 0;
        order_err = 0;
        overflowed = 0;
    endfunction

    function automatic void close_batch();
        int unsigned m;
        if (!open_batch) return;
        if (overflowed) begin
            for (int j = 0; j < in_use(); j++)
                if (find_root(j) != 0) parent[j] = PERSON_W'(j);
        end else begin
            foreach (members[j]) begin
                m = members[j];
                if (find_root(m) != 0) parent[m] = PERSON_W'(m);
            end
        end
        members.delete();
        open_batch = 0;
        overflowed = 0;
    endfunction

    function automatic void apply_item(in_item_t it);
        int unsigned n;
        int unsigned ra;
        int unsigned rb;
        out_item_t   ans;
        n = in_use();
        if (it.command == CMD_QUERY) begin
            close_batch();
            ans.queried_person = it.person_a;
            ans.knows_secret = (it.person_a < n) && (find_root(it.person_a) == 0);
            ans.order_error = order_err;
            answers.push_back(ans);
            return;
        end
        if (it.person_a >= n || it.person_b >= n) return;
        if (it.meeting_time < cur_time) begin
            order_err = 1;
            return;
        end
        if (!open_batch || it.meeting_time != cur_time) begin
            close_batch();
            open_batch = 1;
            cur_time = it.meeting_time;
        end
        ra = find_root(it.person_a);
        rb = find_root(it.person_b);
        if (ra > rb) parent[ra] = PERSON_W'(rb);
        else parent[rb] = PERSON_W'(ra);
        if (members.size() + 2 <= MEMBERS_MAX) begin
            members.push_back(it.person_a);
            members.push_back(it.person_b);
        end else begin
            overflowed = 1;
        end
    endfunction

    always @(posedge aclk) begin
        out_item_t want;
        if (!aresetn) begin
            people_reg = PEOPLE_MAX;
            first_reg = 1;
            restart_table();
            answers.delete();
            fail_count = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (answers.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result transaction: %p", m_data);
                end else begin
                    want = answers.pop_front();
                    if (m_data.queried_person !== want.queried_person
                        || m_data.knows_secret !== want.knows_secret
                        || m_data.order_error !== want.order_error) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display({"mismatch: person exp %0d got %0d, ",
                                      "knows exp %0b got %0b, err exp %0b got %0b"},
                                     want.queried_person, m_data.queried_person,
                                     want.knows_secret, m_data.knows_secret,
                                     want.order_error, m_data.order_error);
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_PEOPLE_COUNT) people_reg = {21'd0, cfg_data[10:0]};
                else first_reg = {22'd0, cfg_data[9:0]};
                restart_table();
            end
            if (s_valid && s_ready) apply_item(s_data);
        end
        answers_due = answers.size();
    end
endmodule

// File: tb/tb_top.sv
// tb_top: stimulus and verdict for temporal_union_find_reachability
// depends on tufr_pkg, tufr_checker and the block itself
`timescale 1ns / 100ps
module tb_top;
    import tufr_pkg::*;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    in_item_t    s_data;
    logic        m_valid;
    logic        m_ready;
    out_item_t   m_data;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [0:0]  cfg_index;
    logic [15:0] cfg_data;
    int          fail_count;
    int          answers_due;

    int          send_idle;
    int          recv_idle;
    logic        hold_start;
    int          hold_left;
    int unsigned people_eff;
    logic [TIME_W-1:0] now_t;
    int          rnd_done;

    temporal_union_find_reachability i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    tufr_checker i_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .answers_due(answers_due)
    );

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #50_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // receiver with an optional long hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 0;
            hold_left <= 0;
        end else if (hold_start) begin
            m_ready <= 0;
            hold_left <= 400;
        end else if (hold_left != 0) begin
            m_ready <= 0;
            hold_left <= hold_left - 1;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= recv_idle);
        end
    end

    task automatic set_mode();
        if (rnd_done < 430) begin
            send_idle = 30;
            recv_idle = 54;
        end else if (rnd_done < 860) begin
            send_idle = 54;
            recv_idle = 30;
        end else begin
            send_idle = 0;
            recv_idle = 0;
        end
    endtask

    task automatic send(input logic cmd, input int unsigned a, input int unsigned b,
                        input logic [TIME_W-1:0] t);
        in_item_t it;
        it.command = cmd;
        it.person_a = PERSON_W'(a);
        it.person_b = PERSON_W'(b);
        it.meeting_time = t;
        set_mode();
        rnd_done++;
        if ($urandom_range(0, 99) < send_idle) begin
            s_valid <= 0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_valid <= 1;
        s_data <= it;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic meet(input int unsigned a, input int unsigned b,
                        input logic [TIME_W-1:0] t);
        send(CMD_MEET, a, b, t);
    endtask

    task automatic query(input int unsigned a);
        send(CMD_QUERY, a, $urandom_range(0, 1023), $urandom);
    endtask

    task automatic settle();
        s_valid <= 0;
        @(posedge aclk);
        while (answers_due != 0) @(posedge aclk);
        do @(posedge aclk); while (!s_ready);
        repeat (16) @(posedge aclk);
    endtask

    task automatic cfg_write(input logic [0:0] idx, input int unsigned val);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= 16'(val);
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 0;
        @(posedge aclk);
    endtask

    task automatic random_items(input int count);
        int unsigned r;
        int unsigned a;
        int unsigned b;
        logic [TIME_W-1:0] t;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            if (r < 25) begin
                if ($urandom_range(0, 9) == 0) query($urandom_range(0, 1023));
                else query($urandom_range(0, people_eff - 1));
            end else begin
                a = $urandom_range(0, people_eff - 1);
                b = $urandom_range(0, people_eff - 1);
                if ($urandom_range(0, 19) == 0) a = $urandom_range(0, 1023);
                if ($urandom_range(0, 19) == 0) b = $urandom_range(0, 1023);
                if ($urandom_range(0, 19) == 0 && now_t != 0) begin
                    t = now_t - $urandom_range(1, 100);
                    if (t > now_t) t = 0;
                end else begin
                    if ($urandom_range(0, 2) == 0) now_t = now_t + $urandom_range(1, 5);
                    t = now_t;
                end
                meet(a, b, t);
            end
        end
    endtask

    task automatic phase(input int unsigned people, input int unsigned first,
                         input int unsigned eff, input int count);
        settle();
        cfg_write(REG_PEOPLE_COUNT, people);
        cfg_write(REG_FIRST_PERSON, first);
        people_eff = eff;
        now_t = $urandom >> 1;
        random_items(count);
    endtask

    initial begin
        aresetn = 0;
        s_valid = 0;
        s_data = '0;
        cfg_valid = 0;
        cfg_index = REG_PEOPLE_COUNT;
        cfg_data = 0;
        hold_start = 0;
        send_idle = 30;
        recv_idle = 54;
        rnd_done = 0;
        repeat (8) @(posedge aclk);
        aresetn <= 1;

        // defaults after reset
        query(0);
        query(1);
        query(1023);
        meet(1, 1023, 5);
        meet(2, 3, 5);
        query(1023);
        query(3);
        meet(3, 0, 5);
        query(3);
        meet(4, 5, 2);
        query(4);
        meet(1022, 1021, 32'hFFFF_FFFF);
        meet(1023, 1022, 32'hFFFF_FFFF);
        query(1021);
        query(1022);

        // first person outside the count, out-of-range persons
        settle();
        cfg_write(REG_PEOPLE_COUNT, 16);
        cfg_write(REG_FIRST_PERSON, 20);
        query(0);
        meet(20, 3, 7);
        meet(3, 1000, 7);
        meet(0, 15, 7);
        query(1000);
        query(20);
        query(15);

        phase(2, 1, 2, 40);
        phase(1024, 1023, 1024, 50);
        settle();
        hold_start <= 1;
        @(posedge aclk);
        hold_start <= 0;
        people_eff = 1024;
        random_items(40);
        phase(16, 20, 16, 40);
        phase(0, 1, 2, 20);
        phase(2047, 0, 1024, 30);
        phase(40, 7, 40, 40);

        // batch list overflow on one time value
        settle();
        cfg_write(REG_PEOPLE_COUNT, 8);
        cfg_write(REG_FIRST_PERSON, 3);
        for (int i = 0; i < 1030; i++)
            meet($urandom_range(1, 7), $urandom_range(1, 7), 100);
        meet(0, 3, 100);
        for (int i = 0; i < 8; i++) query(i);

        settle();
        repeat (50) @(posedge aclk);
        if (fail_count == 0 && answers_due == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
